### hw/rtl/sbo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_pkg
// shared constants and types of the segment box occlusion test
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int COORD_BITS_DEF = 32;

    localparam int SLOT_W   = 4;
    localparam int SHRINK_W = 16;
    localparam int TRIM_W   = 24;
    localparam int CFG_W    = 24;
    localparam int T_FRAC   = 24;
    // slab parameter: sign, two integer bits, fraction
    localparam int T_W      = T_FRAC + 3;
    localparam int T_STEPS  = T_FRAC + 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_BOX_SHRINK   = 1'b0;
    localparam logic REG_SEGMENT_TRIM = 1'b1;

    localparam logic [TRIM_W-1:0] TRIM_RESET   = 24'd17;
    localparam logic [SHRINK_W-1:0] SHRINK_RESET = 16'd1;

    typedef struct packed {
        logic            done;
        logic [T_W-1:0]  t;
    } div_res_t;

endpackage

### hw/rtl/sbo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/sbo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_div
// restoring divider for slab parameters, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbo_div #(
    parameter int W = 35
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [W-1:0]  num,
    input  logic signed [W-1:0]  den,
    output sbo_pkg::div_res_t    res
);

    localparam int CW = $clog2(sbo_pkg::T_STEPS);

    logic            busy_reg;
    logic            done_reg;
    logic            neg_reg;
    logic [W:0]      r_reg;
    logic [W-1:0]    ud_reg;
    logic [sbo_pkg::T_W-1:0] q_reg;
    logic [CW-1:0]   cnt_reg;

    logic [W-1:0]    un;
    logic [W-1:0]    ud;
    logic [W:0]      rs;
    logic [sbo_pkg::T_W-1:0] qs;

    assign un = num[W-1] ? W'(-num) : W'(num);
    assign ud = den[W-1] ? W'(-den) : W'(den);
    // integer bit step uses the remainder unshifted
    assign rs = (cnt_reg == '0) ? r_reg : {r_reg[W-1:0], 1'b0};
    assign qs = {q_reg[sbo_pkg::T_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                neg_reg <= num[W-1] ^ den[W-1];
                ud_reg  <= ud;
                cnt_reg <= '0;
                if ({1'b0, un} >= {ud, 1'b0})
                begin
                    q_reg    <= sbo_pkg::T_W'(2) << sbo_pkg::T_FRAC;
                    done_reg <= 1'b1;
                end
                else
                begin
                    q_reg    <= '0;
                    r_reg    <= {1'b0, un};
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (rs >= {1'b0, ud_reg})
                begin
                    r_reg <= rs - {1'b0, ud_reg};
                    q_reg <= qs | sbo_pkg::T_W'(1);
                end
                else
                begin
                    r_reg <= rs;
                    q_reg <= qs;
                end
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(sbo_pkg::T_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.t    = neg_reg ? -q_reg : q_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(start))
        else $error("divider done held without a new start");
    a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> !busy_reg)
        else $error("divider done while still iterating");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CW'(sbo_pkg::T_STEPS - 1))
        else $error("divider step count out of range");

endmodule

### hw/rtl/segment_box_occlusion_test.sv
`timescale 1ns / 1ps
// a load is taken in idle and the block stays in idle; a query scans the slots in order, skipping invalid
// slots and running the slab test on each valid one with the shared one bit per cycle divider (two
// divisions per axis with a nonzero direction), then the finishing state registers the result to the output
// throughput: one item at a time, next item taken once the block is back in idle
// reset: asynchronous, clears all valid bits and control, configuration registers take their defaults
// ----------------------------------------------------------------------------
// segment_box_occlusion_test
// any-hit slab test of a trimmed segment against a table of shrunk boxes
// ----------------------------------------------------------------------------
module segment_box_occlusion_test #(
    parameter int MAX_BOXES  = sbo_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = sbo_pkg::COORD_BITS_DEF,
    parameter int S_TDATA_W  = ((2 + sbo_pkg::SLOT_W + 6 * COORD_BITS + 6) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // slot, slot_valid, first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [S_TDATA_W-1:0]      s_tdata,
    // operation
    input  logic [0:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // blocked
    output logic [7:0]                m_tdata,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [sbo_pkg::CFG_W-1:0] cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int W   = C + 3;
    localparam int IW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int BW  = 6 * C;
    localparam int TW  = sbo_pkg::T_W;
    localparam int P0  = sbo_pkg::SLOT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_AXIS, S_DIV1, S_DIV2, S_DONE
    } state_t;

    state_t                      state_reg;
    logic [MAX_BOXES-1:0]        valid_reg;
    logic [sbo_pkg::SHRINK_W-1:0] shrink_reg;
    logic [sbo_pkg::TRIM_W-1:0]  trim_reg;
    logic [IW-1:0]               box_reg;
    logic [1:0]                  ax_reg;
    logic                        hit_reg;
    logic [BW-1:0]               seg_reg;
    logic signed [TW-1:0]        tmin_reg;
    logic signed [TW-1:0]        tmax_reg;
    logic signed [TW-1:0]        t1_reg;
    logic signed [W-1:0]         num2_reg;
    logic signed [W-1:0]         d_reg;
    logic                        m_tvalid_reg;
    logic                        blocked_reg;

    logic                        accept;
    logic [31:0]                 slot_ext;
    logic                        slot_ok;
    logic [IW-1:0]               waddr;
    logic                        ram_we;
    logic [BW-1:0]               rdata;
    logic                        last_box;

    logic signed [W-1:0]         lo, hi, p0, p1, sh;
    logic signed [W-1:0]         a, b, a_s, b_s, mid, d;
    logic                        collapse;
    logic                        div_start;
    logic signed [W-1:0]         div_num;
    logic signed [W-1:0]         div_den;
    sbo_pkg::div_res_t           div_res;
    logic signed [TW-1:0]        tlo, thi, ntmin, ntmax;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign slot_ext = 32'(s_tdata[sbo_pkg::SLOT_W-1:0]);
    assign slot_ok  = (slot_ext < 32'(MAX_BOXES));
    assign waddr    = slot_ext[IW-1:0];
    assign ram_we   = accept && (s_tuser[0] == sbo_pkg::OP_LOAD) && slot_ok;
    assign last_box = (box_reg == IW'(MAX_BOXES - 1));

    // box word: low x, y, z then high x, y, z from the lowest bit
    sbo_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (s_tdata[P0 +: BW]),
        .raddr (box_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        case (ax_reg)
            2'd0:
            begin
                lo = W'(signed'(rdata[0 +: C]));
                hi = W'(signed'(rdata[3*C +: C]));
                p0 = W'(signed'(seg_reg[0 +: C]));
                p1 = W'(signed'(seg_reg[3*C +: C]));
            end
            2'd1:
            begin
                lo = W'(signed'(rdata[C +: C]));
                hi = W'(signed'(rdata[4*C +: C]));
                p0 = W'(signed'(seg_reg[C +: C]));
                p1 = W'(signed'(seg_reg[4*C +: C]));
            end
            default:
            begin
                lo = W'(signed'(rdata[2*C +: C]));
                hi = W'(signed'(rdata[5*C +: C]));
                p0 = W'(signed'(seg_reg[2*C +: C]));
                p1 = W'(signed'(seg_reg[5*C +: C]));
            end
        endcase
    end

    assign sh       = W'(signed'({1'b0, shrink_reg}));
    assign a_s      = lo + sh;
    assign b_s      = hi - sh;
    assign mid      = (lo + hi) >>> 1;
    assign collapse = (b_s < a_s);
    assign a        = collapse ? mid : a_s;
    assign b        = collapse ? mid : b_s;
    assign d        = p1 - p0;

    assign div_start = ((state_reg == S_AXIS) && (d != '0))
                    || ((state_reg == S_DIV1) && div_res.done);
    assign div_num   = (state_reg == S_AXIS) ? (a - p0) : num2_reg;
    assign div_den   = (state_reg == S_AXIS) ? d : d_reg;

    sbo_div #(
        .W (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    always_comb
    begin
        if (t1_reg > signed'(div_res.t))
        begin
            tlo = div_res.t;
            thi = t1_reg;
        end
        else
        begin
            tlo = t1_reg;
            thi = div_res.t;
        end
        ntmin = (tlo > tmin_reg) ? tlo : tmin_reg;
        ntmax = (thi < tmax_reg) ? thi : tmax_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            shrink_reg   <= sbo_pkg::SHRINK_RESET;
            trim_reg     <= sbo_pkg::TRIM_RESET;
            box_reg      <= '0;
            ax_reg       <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index[0])
                    sbo_pkg::REG_BOX_SHRINK:
                        shrink_reg <= cfg_data[sbo_pkg::SHRINK_W-1:0];
                    sbo_pkg::REG_SEGMENT_TRIM:
                        trim_reg <= cfg_data[sbo_pkg::TRIM_W-1:0];
                    default: ;
                endcase
            end
            // the finishing state handles the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser[0] == sbo_pkg::OP_LOAD)
                        begin
                            if (slot_ok)
                            begin
                                valid_reg[waddr] <= s_tdata[sbo_pkg::SLOT_W];
                            end
                        end
                        else
                        begin
                            seg_reg   <= s_tdata[P0 +: BW];
                            box_reg   <= '0;
                            hit_reg   <= 1'b0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (valid_reg[box_reg])
                    begin
                        state_reg <= S_WAIT;
                    end
                    else if (last_box)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        box_reg <= box_reg + IW'(1);
                    end
                end
                S_WAIT:
                begin
                    ax_reg    <= '0;
                    tmin_reg  <= TW'(signed'({1'b0, trim_reg}));
                    tmax_reg  <= (TW'(1) << sbo_pkg::T_FRAC)
                               - TW'(signed'({1'b0, trim_reg}));
                    state_reg <= S_AXIS;
                end
                S_AXIS:
                begin
                    if (d != '0)
                    begin
                        num2_reg  <= b - p0;
                        d_reg     <= d;
                        state_reg <= S_DIV1;
                    end
                    else if ((p0 < a) || (p0 > b))
                    begin
                        // point outside the flat slab misses this box
                        if (last_box)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            box_reg   <= box_reg + IW'(1);
                            state_reg <= S_READ;
                        end
                    end
                    else if (ax_reg == 2'd2)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_DIV1:
                begin
                    if (div_res.done)
                    begin
                        t1_reg    <= div_res.t;
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_res.done)
                    begin
                        tmin_reg <= ntmin;
                        tmax_reg <= ntmax;
                        if (ntmin > ntmax)
                        begin
                            if (last_box)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                box_reg   <= box_reg + IW'(1);
                                state_reg <= S_READ;
                            end
                        end
                        else if (ax_reg == 2'd2)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_AXIS;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        blocked_reg  <= hit_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, blocked_reg};

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finishing state");
    a_only_valid_boxes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> valid_reg[box_reg])
        else $error("invalid box entered the slab test");
    a_div_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> ((state_reg == S_DIV1) || (state_reg == S_DIV2)))
        else $error("divider result outside a division state");
    a_no_ram_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("box table written during a query");

endmodule

### test/segment_box_occlusion_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_occlusion_test_test
// streams box loads and segment queries with random gaps and stalls, predicts
// each blocked flag with a bit-true slab test and compares it in order
// ----------------------------------------------------------------------------
class occlusion_board;
    int unsigned shrink;
    int unsigned trim;
    bit            slot_on [16];
    longint        lo [16][3];
    longint        hi [16][3];
    bit            pending [$];
    int            errors;

    function new();
        shrink = 1;
        trim = 17;
        errors = 0;
        foreach (slot_on[i]) slot_on[i] = 0;
    endfunction

    // signed quotient with 24 fraction bits, truncated, saturated at 2.0
    function longint slab_t(longint num, longint den);
        bit neg;
        longint un, ud, q, r;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        if (un >= 2 * ud)
            q = longint'(2) << 24;
        else
        begin
            q = un / ud;
            r = un % ud;
            for (int k = 0; k < 24; k++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= ud)
                begin
                    q = q | 1;
                    r = r - ud;
                end
            end
        end
        return neg ? -q : q;
    endfunction

    function bit hits_box(longint p0 [3], longint p1 [3], int n);
        longint tmin, tmax, a, b, d, t1, t2, s;
        tmin = trim;
        tmax = (longint'(1) << 24) - trim;
        for (int ax = 0; ax < 3; ax++)
        begin
            a = lo[n][ax] + shrink;
            b = hi[n][ax] - shrink;
            d = p1[ax] - p0[ax];
            if (b < a)
            begin
                s = lo[n][ax] + hi[n][ax];
                a = s >>> 1;
                b = a;
            end
            if (d == 0)
            begin
                if (p0[ax] < a || p0[ax] > b) return 0;
            end
            else
            begin
                t1 = slab_t(a - p0[ax], d);
                t2 = slab_t(b - p0[ax], d);
                if (t1 > t2)
                begin
                    s = t1;
                    t1 = t2;
                    t2 = s;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) return 0;
            end
        end
        return 1;
    endfunction

    function void note_item(bit op, int slot, bit valid, longint c1 [3], longint c2 [3]);
        bit hit;
        if (op == sbo_pkg::OP_LOAD)
        begin
            slot_on[slot] = valid;
            for (int k = 0; k < 3; k++)
            begin
                lo[slot][k] = c1[k];
                hi[slot][k] = c2[k];
            end
        end
        else
        begin
            hit = 0;
            for (int n = 0; n < 16; n++)
                if (slot_on[n] && !hit && hits_box(c1, c2, n)) hit = 1;
            pending.push_back(hit);
        end
    endfunction

    function void check_blocked(logic [7:0] got);
        bit want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== {7'd0, want})
        begin
            errors++;
            if (errors <= 10) $display("blocked mismatch: expected %0d got %h", want, got);
        end
    endfunction
endclass

module segment_box_occlusion_test_test;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [199:0]          s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [7:0]            m_tdata;
    logic                  cfg_we = 0;
    logic [0:0]            cfg_index = '0;
    logic [sbo_pkg::CFG_W-1:0] cfg_data = '0;

    occlusion_board board = new();
    int burst_left = 0;
    int stall_mode = 0;

    segment_box_occlusion_test dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) board.check_blocked(m_tdata);

    // receiver: phases of never stalling, light and heavy stalling
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function longint rand_coord(int spread);
        case (spread)
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom_range(0, 8191))) - 4096;
            default: return longint'(int'($urandom_range(0, 40) * 32'h10000)) - 32'h140000;
        endcase
    endfunction

    task automatic send_item(bit op, int slot, bit valid, longint c1 [3], longint c2 [3]);
        if (burst_left == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tuser <= op;
        s_tdata <= {3'b000, c2[2][31:0], c2[1][31:0], c2[0][31:0],
                    c1[2][31:0], c1[1][31:0], c1[0][31:0], valid, slot[3:0]};
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_item(op, slot, valid, c1, c2);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (board.pending.size() != 0) @(negedge clk);
        // a trailing load may still be in flight
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= sbo_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we <= 0;
        if (idx == sbo_pkg::REG_BOX_SHRINK) board.shrink = value;
        else board.trim = value;
    endtask

    task automatic random_item(int spread);
        longint c1 [3], c2 [3];
        longint t;
        bit op;
        op = ($urandom_range(0, 2) != 0);
        for (int k = 0; k < 3; k++)
        begin
            c1[k] = rand_coord(spread);
            c2[k] = rand_coord(spread);
            if (!op && $urandom_range(0, 5) != 0 && c1[k] > c2[k])
            begin
                t = c1[k];
                c1[k] = c2[k];
                c2[k] = t;
            end
            if (op && $urandom_range(0, 9) == 0) c2[k] = c1[k];
        end
        send_item(op, $urandom_range(0, 15), $urandom_range(0, 3) != 0, c1, c2);
    endtask

    initial
    begin
        longint a [3], b [3], m [3], z [3];
        int spread;
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // query with empty table
        a = '{-65536, 0, 0}; b = '{65536, 0, 0}; z = '{0, 0, 0};
        send_item(sbo_pkg::OP_QUERY, 0, 0, a, b);
        // unit box at origin
        a = '{-65536, -65536, -65536}; b = '{65536, 65536, 65536};
        send_item(sbo_pkg::OP_LOAD, 0, 1, a, b);
        m = '{-131072, 0, 0}; b = '{131072, 0, 0};
        send_item(sbo_pkg::OP_QUERY, 0, 0, m, b);
        send_item(sbo_pkg::OP_QUERY, 0, 0, z, z);
        m = '{0, 0, 200000}; send_item(sbo_pkg::OP_QUERY, 0, 0, m, m);
        // collapsed box on every axis
        a = '{10, 10, 10}; b = '{11, 11, 11};
        send_item(sbo_pkg::OP_LOAD, 15, 1, a, b);
        a = '{10, 10, 0}; b = '{10, 10, 40};
        send_item(sbo_pkg::OP_QUERY, 0, 0, a, b);
        // field extremes
        a = '{-2147483647 - 1, -2147483647 - 1, -2147483647 - 1};
        b = '{2147483647, 2147483647, 2147483647};
        send_item(sbo_pkg::OP_LOAD, 7, 1, a, b);
        send_item(sbo_pkg::OP_QUERY, 0, 0, a, b);
        send_item(sbo_pkg::OP_QUERY, 0, 0, b, a);
        send_item(sbo_pkg::OP_LOAD, 7, 0, a, b);
        send_item(sbo_pkg::OP_QUERY, 15, 1, b, a);
        write_reg(sbo_pkg::REG_SEGMENT_TRIM, 24'h800000);
        m = '{-131072, 0, 0}; b = '{131072, 0, 0};
        send_item(sbo_pkg::OP_QUERY, 0, 0, m, b);
        send_item(sbo_pkg::OP_QUERY, 0, 0, z, z);
        write_reg(sbo_pkg::REG_SEGMENT_TRIM, 24'hFFFFFF);
        send_item(sbo_pkg::OP_QUERY, 0, 0, m, b);
        write_reg(sbo_pkg::REG_BOX_SHRINK, 16'hFFFF);
        send_item(sbo_pkg::OP_QUERY, 0, 0, m, b);
        write_reg(sbo_pkg::REG_SEGMENT_TRIM, 0);
        write_reg(sbo_pkg::REG_BOX_SHRINK, 0);
        send_item(sbo_pkg::OP_QUERY, 0, 0, m, b);
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: write_reg(sbo_pkg::REG_BOX_SHRINK, 1);
                2: write_reg(sbo_pkg::REG_SEGMENT_TRIM, 17);
                3: write_reg(sbo_pkg::REG_BOX_SHRINK, $urandom_range(0, 65535));
                4: write_reg(sbo_pkg::REG_SEGMENT_TRIM, $urandom_range(0, 24'h800000));
                5: write_reg(sbo_pkg::REG_SEGMENT_TRIM, $urandom_range(0, 24'hFFFFFF));
                default: ;
            endcase
            for (int i = 0; i < 250; i++)
            begin
                spread = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
                random_item(spread);
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
hw/rtl/sbo_pkg.sv
hw/rtl/sbo_ram.sv
hw/rtl/sbo_div.sv
hw/rtl/segment_box_occlusion_test.sv
test/segment_box_occlusion_test_test.sv
